// ----- hdl/assert_macros.svh -----
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CCSR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("ccsr assertion failed");
`define CCSR_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("ccsr forbidden condition");
`else
`define CCSR_ASSERT(lbl, clk, rst_n, prop)
`define CCSR_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- hdl/ccsr_pkg.sv -----
`default_nettype none
package ccsr_pkg;
	localparam int MODE_W  = 3;
	localparam int COORD_W = 12;
	localparam int SIZE_W  = 11;
	localparam int GLYPH_W = 8;

	localparam logic [MODE_W-1:0] MODE_LINE      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RECT      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CIRCLE    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TRIANGLE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLR_AREA  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLR_ALL   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_READ      = 3'd6;

	localparam logic [GLYPH_W-1:0] SPACE_CODE = 8'd32;
endpackage
`default_nettype wire

// ----- hdl/char_canvas_shape_rasterizer_top.sv -----
// Line: a slope division first when steps > 0, then steps+1 points; rectangle, triangle,
//   clear area and clear all scan all ROWS*COLS cells, circle after a setup state; read via ST_RD.
// Throughput: one command at a time, bound by the single canvas write port (one cell/cycle).
// Reset: asynchronous, active low; a clearing pass then writes space to all ROWS*COLS
//   cells, one a cycle, with s_tready low until the pass is done.
`default_nettype none
`include "assert_macros.svh"
module char_canvas_shape_rasterizer_top #(
	parameter int CANVAS_ROWS = 25,
	parameter int CANVAS_COLS = 60,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// row_a[11:0] col_a[23:12] row_b[35:24] col_b[47:36] height[58:48]
	// width[69:59] radius[80:70] glyph[88:81], zero fill above
	input  wire logic [95:0] s_tdata,
	// mode[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// cell_value[7:0]
	output logic      [7:0]  m_tdata,
	// in_range[0]
	output logic      [0:0]  m_tuser
);
	localparam int CELLS = CANVAS_ROWS * CANVAS_COLS;
	localparam int AW = CELLS > 1 ? $clog2(CELLS) : 1;
	localparam int RW = CANVAS_ROWS > 1 ? $clog2(CANVAS_ROWS) : 1;
	localparam int CW = CANVAS_COLS > 1 ? $clog2(CANVAS_COLS) : 1;
	localparam int PW = FRAC_BITS + 14;
	localparam int NW = FRAC_BITS + 12;
	localparam int QW = FRAC_BITS + 1;
	localparam int SQW = 27;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_LINE  = 3'd3;
	localparam logic [2:0] ST_SETUP = 3'd4;
	localparam logic [2:0] ST_RD    = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic       boot_q;
	logic [2:0] mode_q;
	logic signed [11:0] ra_q, ca_q;
	logic [10:0] height_q, width_q, rad_q;
	logic [7:0]  glyph_q;

	logic [RW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [AW-1:0] addr_q;

	logic signed [PW-1:0] pr_q, pc_q, ir_q, ic_q;
	logic [11:0] k_q, dr_q, dc_q, steps_q;
	logic        negr_q, negc_q;

	logic signed [13:0] a_q;
	logic signed [12:0] b_q;
	logic [SQW-1:0] asq_q, bsq_q, ccsq_q;
	logic [22:0]    rlo_q, rhi_q;

	logic [AW-1:0] rd_addr_q;
	logic          rd_ok_q;

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tuser_q;

	// unpack the incoming word
	logic [2:0]          s_mode;
	logic signed [11:0]  s_ra, s_ca, s_rb, s_cb;
	assign s_mode = s_tuser;
	assign s_ra   = s_tdata[11:0];
	assign s_ca   = s_tdata[23:12];
	assign s_rb   = s_tdata[35:24];
	assign s_cb   = s_tdata[47:36];

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// line setup: deltas, step count and divider operand
	logic signed [12:0] drow, dcol;
	logic [11:0] s_dr, s_dc, s_steps, s_min;
	assign drow    = 13'(s_rb) - 13'(s_ra);
	assign dcol    = 13'(s_cb) - 13'(s_ca);
	assign s_dr    = drow[12] ? 12'(-drow) : drow[11:0];
	assign s_dc    = dcol[12] ? 12'(-dcol) : dcol[11:0];
	assign s_steps = (s_dr > s_dc) ? s_dr : s_dc;
	assign s_min   = (s_dr > s_dc) ? s_dc : s_dr;

	logic          div_start;
	logic          div_done;
	logic [NW-1:0] div_num;
	logic [QW-1:0] div_quo;
	assign div_start = accept && (s_mode == ccsr_pkg::MODE_LINE) && (s_steps != '0);
	assign div_num = {s_min, {FRAC_BITS{1'b0}}} + NW'(s_steps[11:1]);

	ccsr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (s_steps),
		.done  (div_done),
		.quo   (div_quo)
	);

	// read position check
	logic s_rd_in;
	assign s_rd_in = !s_ra[11] && !s_ca[11]
		&& (s_ra < $signed(12'(CANVAS_ROWS))) && (s_ca < $signed(12'(CANVAS_COLS)));

	// line point: truncate the fixed-point position toward zero
	logic signed [PW-1:0] rmag, cmag;
	logic signed [13:0]   tr_row, tr_col;
	logic                 line_in;
	logic [AW-1:0]        line_addr;
	assign rmag   = pr_q[PW-1] ? -pr_q : pr_q;
	assign cmag   = pc_q[PW-1] ? -pc_q : pc_q;
	assign tr_row = pr_q[PW-1] ? -rmag[PW-1:FRAC_BITS] : rmag[PW-1:FRAC_BITS];
	assign tr_col = pc_q[PW-1] ? -cmag[PW-1:FRAC_BITS] : cmag[PW-1:FRAC_BITS];
	assign line_in = !tr_row[13] && !tr_col[13]
		&& (tr_row < $signed(14'(CANVAS_ROWS))) && (tr_col < $signed(14'(CANVAS_COLS)));
	assign line_addr = AW'(AW'(tr_row[RW-1:0]) * AW'(CANVAS_COLS)) + AW'(tr_col[CW-1:0]);

	// scan predicates for the current cell
	logic signed [13:0] iv, jv, r14, c14, rh, cw, kk, dj, adj;
	logic in_rect, on_edge, tri_hit, circ_hit;
	logic [SQW-1:0] sq_dist;
	assign iv  = 14'(i_q);
	assign jv  = 14'(j_q);
	assign r14 = 14'(ra_q);
	assign c14 = 14'(ca_q);
	assign rh  = r14 + 14'(height_q);
	assign cw  = c14 + 14'(width_q);
	assign in_rect = (iv >= r14) && (iv < rh) && (jv >= c14) && (jv < cw);
	assign on_edge = (iv == r14) || (iv == rh - 14'sd1) || (jv == c14) || (jv == cw - 14'sd1);
	assign kk  = iv - r14;
	assign dj  = jv - c14;
	assign adj = dj[13] ? -dj : dj;
	assign tri_hit = !kk[13] && (kk < $signed(14'(height_q))) && (adj <= kk);
	assign sq_dist = asq_q + bsq_q;
	assign circ_hit = (sq_dist >= SQW'(rlo_q)) && (sq_dist <= SQW'(rhi_q));

	logic last_col, last_cell;
	assign last_col  = (j_q == CW'(CANVAS_COLS - 1));
	assign last_cell = last_col && (i_q == RW'(CANVAS_ROWS - 1));

	// canvas write port
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [7:0]    rdata;

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = ccsr_pkg::SPACE_CODE;
		if (state_q == ST_SCAN) begin
			case (mode_q)
				ccsr_pkg::MODE_RECT:     we = in_rect && on_edge;
				ccsr_pkg::MODE_CIRCLE:   we = circ_hit;
				ccsr_pkg::MODE_TRIANGLE: we = tri_hit;
				ccsr_pkg::MODE_CLR_AREA: we = in_rect;
				default:                 we = 1'b1;
			endcase
			if (mode_q inside {ccsr_pkg::MODE_RECT, ccsr_pkg::MODE_CIRCLE,
					ccsr_pkg::MODE_TRIANGLE}) begin
				wdata = glyph_q;
			end
		end else if (state_q == ST_LINE) begin
			we    = line_in;
			waddr = line_addr;
			wdata = glyph_q;
		end
	end

	ccsr_ram #(.DATA_W(8), .DEPTH(CELLS)) u_canvas (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	// slope increments once the divider finishes
	logic signed [PW-1:0] one_fix, inc_q, inc_r, inc_c;
	assign one_fix = PW'(1) <<< FRAC_BITS;
	assign inc_q   = PW'(div_quo);
	assign inc_r   = (dr_q == steps_q) ? one_fix : inc_q;
	assign inc_c   = (dc_q == steps_q) ? one_fix : inc_q;

	// load the result word when the output register is free
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SCAN;
			boot_q     <= 1'b1;
			mode_q     <= ccsr_pkg::MODE_CLR_ALL;
			i_q        <= '0;
			j_q        <= '0;
			addr_q     <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= s_mode;
						i_q    <= '0;
						j_q    <= '0;
						addr_q <= '0;
						k_q    <= s_steps;
						case (s_mode)
							ccsr_pkg::MODE_LINE:
								state_q <= (s_steps == '0) ? ST_LINE : ST_DIV;
							ccsr_pkg::MODE_CIRCLE: state_q <= ST_SETUP;
							ccsr_pkg::MODE_READ:   state_q <= ST_RD;
							ccsr_pkg::MODE_RECT, ccsr_pkg::MODE_TRIANGLE,
							ccsr_pkg::MODE_CLR_AREA, ccsr_pkg::MODE_CLR_ALL:
								state_q <= ST_SCAN;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SETUP: state_q <= ST_SCAN;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_LINE;
					end
				end
				ST_LINE: begin
					if (k_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (last_col) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					if (last_cell) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_RD: state_q <= ST_DONE;
				ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ra_q     <= s_ra;
			ca_q     <= s_ca;
			height_q <= s_tdata[58:48];
			width_q  <= s_tdata[69:59];
			rad_q    <= s_tdata[80:70];
			glyph_q  <= s_tdata[88:81];
			dr_q     <= s_dr;
			dc_q     <= s_dc;
			steps_q  <= s_steps;
			negr_q   <= !(s_ra < s_rb);
			negc_q   <= !(s_ca < s_cb);
			pr_q     <= PW'(s_ra) <<< FRAC_BITS;
			pc_q     <= PW'(s_ca) <<< FRAC_BITS;
			rd_ok_q  <= s_rd_in;
			rd_addr_q <= AW'(AW'(s_ra[RW-1:0]) * AW'(CANVAS_COLS)) + AW'(s_ca[CW-1:0]);
		end
		if (state_q == ST_DIV && div_done) begin
			ir_q <= negr_q ? -inc_r : inc_r;
			ic_q <= negc_q ? -inc_c : inc_c;
		end
		if (state_q == ST_LINE) begin
			pr_q <= pr_q + ir_q;
			pc_q <= pc_q + ic_q;
		end
		if (state_q == ST_SETUP) begin
			ccsq_q <= SQW'(ca_q * ca_q);
			bsq_q  <= SQW'(ca_q * ca_q);
			asq_q  <= SQW'(ra_q * ra_q) << 2;
			a_q    <= -(14'(ra_q) <<< 1);
			b_q    <= -13'(ca_q);
			rlo_q  <= 23'(rad_q * rad_q) - 23'(rad_q);
			rhi_q  <= 23'(rad_q * rad_q) + 23'(rad_q);
		end
		if (state_q == ST_SCAN) begin
			// advance the squared distances by first differences
			if (last_col) begin
				asq_q <= SQW'($signed({1'b0, asq_q}) + ($signed(28'(a_q)) <<< 2) + 28'sd4);
				a_q   <= a_q + 14'sd2;
				b_q   <= -13'(ca_q);
				bsq_q <= ccsq_q;
			end else begin
				bsq_q <= SQW'($signed({1'b0, bsq_q}) + ($signed(28'(b_q)) <<< 1) + 28'sd1);
				b_q   <= b_q + 13'sd1;
			end
		end
		if (out_load) begin
			m_tuser_q <= (mode_q == ccsr_pkg::MODE_READ) && rd_ok_q;
			m_tdata_q <= ((mode_q == ccsr_pkg::MODE_READ) && rd_ok_q) ? rdata : 8'd0;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	`CCSR_NEVER(a_no_write_idle, clk, arst_n, (state_q == ST_IDLE) && we)
	`CCSR_ASSERT(a_load_from_done, clk, arst_n, $rose(m_tvalid) |-> $past(state_q) == ST_DONE)
	`CCSR_ASSERT(a_zero_when_out, clk, arst_n, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
	`CCSR_NEVER(a_no_accept_boot, clk, arst_n, boot_q && s_tready)
endmodule
`default_nettype wire

// ----- hdl/ccsr_ram.sv -----
`default_nettype none
module ccsr_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 1500
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [DATA_W-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [DATA_W-1:0]                      rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/ccsr_div.sv -----
`default_nettype none
// Restoring long division, one numerator bit per cycle.
module ccsr_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [FRAC_BITS+11:0]   num,
	input  wire logic [11:0]             den,
	output logic                         done,
	output logic      [FRAC_BITS:0]      quo
);
	localparam int NW = FRAC_BITS + 12;
	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   num_q;
	logic [NW-1:0]   quo_q;
	logic [11:0]     rem_q;
	logic [11:0]     den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [12:0]     rem_sh;
	logic            fits;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= fits ? 12'(rem_sh - {1'b0, den_q}) : rem_sh[11:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign quo = quo_q[FRAC_BITS:0];
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;
	localparam int ROWS = 25;
	localparam int COLS = 60;
	localparam int FRAC = 16;
	localparam int CELLS = ROWS * COLS;
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	typedef struct {
		logic [7:0] cell_value;
		logic       in_range;
	} readout_t;

	typedef struct {
		logic [2:0]  mode;
		logic [11:0] row_a, col_a, row_b, col_b;
		logic [10:0] height, width, radius;
		logic [7:0]  glyph;
	} cmd_t;

	// Scoreboard: holds its own canvas copy and the queue of pending readouts.
	class canvas_scoreboard;
		logic [7:0] canvas [CELLS];
		readout_t   pending [$];
		int         errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			for (int n = 0; n < CELLS; n++) canvas[n] = ccsr_pkg::SPACE_CODE;
		endfunction

		function void plot(longint r, longint c, logic [7:0] g);
			if (r >= 0 && r < ROWS && c >= 0 && c < COLS) canvas[r * COLS + c] = g;
		endfunction

		function longint trunc_pos(longint p);
			if (p >= 0) return p >>> FRAC;
			return -((-p) >>> FRAC);
		endfunction

		function void line(longint r0, longint c0, longint r1, longint c1, logic [7:0] g);
			longint dr, dc, steps, ir, ic, pr, pc;
			dr = (r1 > r0) ? r1 - r0 : r0 - r1;
			dc = (c1 > c0) ? c1 - c0 : c0 - c1;
			steps = dr > dc ? dr : dc;
			if (steps == 0) begin
				plot(r0, c0, g);
				return;
			end
			ir = ((dr << FRAC) + steps / 2) / steps;
			ic = ((dc << FRAC) + steps / 2) / steps;
			if (!(r0 < r1)) ir = -ir;
			if (!(c0 < c1)) ic = -ic;
			pr = r0 << FRAC;
			pc = c0 << FRAC;
			for (longint k = 0; k <= steps; k++) begin
				plot(trunc_pos(pr), trunc_pos(pc), g);
				pr += ir;
				pc += ic;
			end
		endfunction

		function void region(longint r, longint c, longint h, longint w, bit outline,
				logic [7:0] g);
			for (longint i = 0; i < ROWS; i++)
				for (longint j = 0; j < COLS; j++)
					if (i >= r && i < r + h && j >= c && j < c + w)
						if (!outline || i == r || i == r + h - 1 || j == c || j == c + w - 1)
							plot(i, j, g);
		endfunction

		// Note an accepted command: update the canvas and queue the readout.
		function void note_command(cmd_t cmd);
			longint ra, ca, rb, cb, h, w, rad, a, b, d;
			readout_t res;
			ra = longint'(signed'(cmd.row_a));
			ca = longint'(signed'(cmd.col_a));
			rb = longint'(signed'(cmd.row_b));
			cb = longint'(signed'(cmd.col_b));
			h = cmd.height;
			w = cmd.width;
			rad = cmd.radius;
			res.cell_value = '0;
			res.in_range = 1'b0;
			case (cmd.mode)
				ccsr_pkg::MODE_LINE: line(ra, ca, rb, cb, cmd.glyph);
				ccsr_pkg::MODE_RECT: region(ra, ca, h, w, 1'b1, cmd.glyph);
				ccsr_pkg::MODE_CIRCLE: begin
					for (longint i = 0; i < ROWS; i++)
						for (longint j = 0; j < COLS; j++) begin
							a = (i - ra) * 2;
							b = j - ca;
							d = a * a + b * b;
							if (d >= rad * rad - rad && d <= rad * rad + rad) plot(i, j, cmd.glyph);
						end
				end
				ccsr_pkg::MODE_TRIANGLE: begin
					for (longint i = 0; i < ROWS; i++)
						for (longint j = 0; j < COLS; j++)
							if (i - ra >= 0 && i - ra < h &&
									((j > ca) ? j - ca : ca - j) <= i - ra)
								plot(i, j, cmd.glyph);
				end
				ccsr_pkg::MODE_CLR_AREA: region(ra, ca, h, w, 1'b0, ccsr_pkg::SPACE_CODE);
				ccsr_pkg::MODE_CLR_ALL: wipe();
				ccsr_pkg::MODE_READ: begin
					if (ra >= 0 && ra < ROWS && ca >= 0 && ca < COLS) begin
						res.cell_value = canvas[ra * COLS + ca];
						res.in_range = 1'b1;
					end
				end
				default: ;
			endcase
			pending.push_back(res);
		endfunction

		function void check_readout(logic [7:0] value, logic ok);
			readout_t exp_res;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: cell_value %0d in_range %0d", value, ok);
				return;
			end
			exp_res = pending.pop_front();
			if (value !== exp_res.cell_value || ok !== exp_res.in_range) begin
				errors++;
				if (errors <= 10)
					$display("word mismatch: exp cell_value %0d in_range %0d, got %0d %0d",
						exp_res.cell_value, exp_res.in_range, value, ok);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;

	canvas_scoreboard sb = new();
	bit stim_done = 1'b0;

	always #6 clk = ~clk;

	char_canvas_shape_rasterizer_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// No gap half the time, else mostly short gaps and a few long ones.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Drive one command word and hold it until the block takes it.
	task automatic send_command(cmd_t cmd);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd.mode;
		s_tdata <= {7'd0, cmd.glyph, cmd.radius, cmd.width, cmd.height,
			cmd.col_b, cmd.row_b, cmd.col_a, cmd.row_a};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd);
	endtask

	// Coordinates mostly near the canvas, sometimes anywhere in the field.
	function automatic logic [11:0] pick_coord(int span);
		if ($urandom_range(0, 9) == 0) return 12'($urandom);
		return 12'($urandom_range(0, span + 16) - 8);
	endfunction

	function automatic logic [10:0] pick_size();
		int p;
		p = $urandom_range(0, 19);
		if (p == 0) return 11'($urandom);
		if (p == 1) return 11'd2047;
		return 11'($urandom_range(0, 30));
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) c.mode = ccsr_pkg::MODE_READ;
		else if (p < 42) c.mode = ccsr_pkg::MODE_CLR_ALL;
		else if (p < 43) c.mode = MODE_UNUSED;
		else c.mode = 3'($urandom_range(0, 4));
		c.row_a = pick_coord(ROWS);
		c.col_a = pick_coord(COLS);
		c.row_b = pick_coord(ROWS);
		c.col_b = pick_coord(COLS);
		c.height = pick_size();
		c.width = pick_size();
		c.radius = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 40));
		c.glyph = 8'($urandom);
		return c;
	endfunction

	function automatic cmd_t make_cmd(logic [2:0] m, int ra, int ca, int rb, int cb,
			int h, int w, int rad, int g);
		cmd_t c;
		c.mode = m;
		c.row_a = 12'(ra); c.col_a = 12'(ca); c.row_b = 12'(rb); c.col_b = 12'(cb);
		c.height = 11'(h); c.width = 11'(w); c.radius = 11'(rad); c.glyph = 8'(g);
		return c;
	endfunction

	// Stimulus: directed corners first, then random commands.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		send_command(make_cmd(ccsr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(ccsr_pkg::MODE_LINE, 3, 4, 3, 4, 0, 0, 0, 255));
		send_command(make_cmd(ccsr_pkg::MODE_READ, 3, 4, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(ccsr_pkg::MODE_LINE, -2048, -2048, 2047, 2047, 0, 0, 0, 65));
		send_command(make_cmd(ccsr_pkg::MODE_LINE, 24, 59, 0, 7, 0, 0, 0, 66));
		send_command(make_cmd(ccsr_pkg::MODE_LINE, 2, 50, 20, 1, 0, 0, 0, 1));
		send_command(make_cmd(ccsr_pkg::MODE_RECT, 1, 2, 0, 0, 10, 20, 0, 67));
		send_command(make_cmd(ccsr_pkg::MODE_RECT, -2048, -2048, 0, 0, 2047, 2047, 0, 68));
		send_command(make_cmd(ccsr_pkg::MODE_RECT, 5, 5, 0, 0, 0, 9, 0, 69));
		send_command(make_cmd(ccsr_pkg::MODE_CIRCLE, 12, 30, 0, 0, 0, 0, 20, 70));
		send_command(make_cmd(ccsr_pkg::MODE_CIRCLE, 12, 30, 0, 0, 0, 0, 0, 71));
		send_command(make_cmd(ccsr_pkg::MODE_CIRCLE, 2047, -2048, 0, 0, 0, 0, 2047, 72));
		send_command(make_cmd(ccsr_pkg::MODE_TRIANGLE, 0, 30, 0, 0, 25, 0, 0, 73));
		send_command(make_cmd(ccsr_pkg::MODE_TRIANGLE, -5, 0, 0, 0, 2047, 0, 0, 74));
		send_command(make_cmd(ccsr_pkg::MODE_READ, 24, 59, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(ccsr_pkg::MODE_READ, 24, 60, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(ccsr_pkg::MODE_READ, -1, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(ccsr_pkg::MODE_CLR_AREA, 0, 0, 0, 0, 10, 30, 0, 0));
		send_command(make_cmd(ccsr_pkg::MODE_READ, 5, 5, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(MODE_UNUSED, 1, 1, 1, 1, 1, 1, 1, 1));
		send_command(make_cmd(ccsr_pkg::MODE_CLR_ALL, 0, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(ccsr_pkg::MODE_READ, 12, 30, 0, 0, 0, 0, 0, 0));
		for (int n = 0; n < 400; n++) send_command(random_command());
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Result side: stall at random and check each accepted word.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_readout(m_tdata, m_tuser[0]);
			m_tready <= (gap_len() == 0);
		end
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("char_canvas_shape_rasterizer_top: match");
		end else begin
			$display("char_canvas_shape_rasterizer_top: mismatch");
		end
		$finish;
	end

	// Generous bound for ~420 commands, even with the longest stalls.
	initial begin
		#100ms;
		$display("char_canvas_shape_rasterizer_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
